>>> src/gbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT_DEF  = 64;
    localparam int MAX_BOXES_DEF = 4096;

    localparam int          THR_W     = 9;
    localparam logic [8:0]  THR_RESET = 9'd128;
    localparam logic [11:0] INDEX_MAX = 12'd4095;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic               last_box;
    } in_t;

    typedef struct packed {
        logic [11:0] box_index;
        logic        kept;
        logic        store_full;
        logic        end_of_set;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic area;
        logic issue;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic pipe_empty;
        logic out_free;
    } stat_t;

endpackage

>>> src/greedy_box_suppression.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression by overlap ratio over score-sorted boxes.
// ----------------------------------------------------------------------------
//  channel  | signals                       | moves
//  ---------+-------------------------------+--------------------------------
//  in       | in_valid, in_ready, in_data   | one box per transfer
//  out      | out_valid, out_ready, out_data| one verdict per box
//  cfg      | cfg_wr_en, cfg_wr_data        | suppression threshold, Q8
//
//  Each box passes through capture, area, one stored entry per cycle through
//  the single read port, scan end, then a drain of the overlap pipeline and
//  the verdict load before the next box can be taken.
//  One box is in work at a time; the next is taken while a verdict waits in
//  the output register.
//  Reset clears counters and state; the store needs no clearing.
//  A stalled output holds the verdict and blocks only the final hand-over.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
    parameter int MAX_KEPT  = gbs_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gbs_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output gbs_pkg::out_t out_data,
    input  logic          cfg_wr_en,
    input  logic [8:0]    cfg_wr_data
);
    import gbs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbs_dp #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

>>> src/gbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: capture a box, form its area, walk the kept store, drain the
// overlap pipeline and hand the decision to the output register.
// ----------------------------------------------------------------------------
module gbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gbs_pkg::stat_t stat,
    output gbs_pkg::cmd_t  cmd
);
    import gbs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_AREA;
                end
            end
            ST_AREA:
            begin
                cmd.area   = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last comparison and a free output slot
                if (stat.pipe_empty && stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/gbs_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_dp
// Datapath: kept-box store, overlap pipeline (one stored box per cycle),
// counters, threshold register and output register.
// ----------------------------------------------------------------------------
module gbs_dp #(
    parameter int MAX_KEPT  = gbs_pkg::MAX_KEPT_DEF,
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gbs_pkg::cmd_t  cmd,
    output gbs_pkg::stat_t stat,
    input  gbs_pkg::in_t   in_data,
    input  logic           cfg_wr_en,
    input  logic [8:0]     cfg_wr_data,
    output logic           out_valid,
    input  logic           out_ready,
    output gbs_pkg::out_t  out_data
);
    import gbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int BW = $clog2(MAX_BOXES);

    // store
    logic [31:0] corner_mem [MAX_KEPT];
    logic [29:0] size_mem   [MAX_KEPT];
    logic [29:0] area_mem   [MAX_KEPT];

    // control state
    logic [THR_W-1:0] thr_reg;
    logic [CW-1:0]    kept_count_reg;
    logic [CW-1:0]    scan_idx_reg;
    logic [BW-1:0]    box_counter_reg;
    logic             suppress_reg;
    logic             out_valid_reg;
    logic [6:1]       v_reg;

    // payload
    in_t          box_reg;
    logic [29:0]  area_a_reg;
    out_t         out_reg;
    logic [31:0]  rd_corner_reg;
    logic [29:0]  rd_size_reg;
    logic [29:0]  rd_area_reg;
    logic signed [16:0] xr_min_reg, xl_max_reg, yr_min_reg, yl_max_reg;
    logic [29:0]  area_b2_reg, area_b3_reg, area_b4_reg;
    logic         ov_reg;
    logic [14:0]  iw_reg, ih_reg;
    logic [29:0]  inter4_reg, inter5_reg;
    logic [30:0]  uni_reg;
    logic [37:0]  lhs_reg;
    logic [39:0]  rhs_reg;

    // combinational
    logic signed [16:0] ax_l, ay_l, ax_r, ay_r, bx_l, by_l, bx_r, by_r;
    logic signed [17:0] iw_s, ih_s;
    logic [29:0]  area_a_next;
    logic [29:0]  inter_next;
    logic [30:0]  uni_next;
    logic [39:0]  rhs_next;
    logic         keep;
    logic         room;
    logic         store_wr;
    logic [11:0]  idx_sat;
    logic         out_load;

    assign room     = (kept_count_reg != CW'(MAX_KEPT));
    assign keep     = !suppress_reg;
    assign store_wr = cmd.finish && keep && room;
    assign out_load = cmd.finish;

    assign stat.scan_end   = (scan_idx_reg == kept_count_reg);
    assign stat.pipe_empty = (v_reg == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (32'(box_counter_reg) > 32'(INDEX_MAX))
        begin
            idx_sat = INDEX_MAX;
        end
        else
        begin
            idx_sat = 12'(box_counter_reg);
        end
    end

    // edges of the incoming box (a) and the stored box (b)
    assign ax_l = {box_reg.box_x[15], box_reg.box_x};
    assign ay_l = {box_reg.box_y[15], box_reg.box_y};
    assign ax_r = ax_l + $signed({2'b00, box_reg.box_width});
    assign ay_r = ay_l + $signed({2'b00, box_reg.box_height});
    assign bx_l = {rd_corner_reg[15], rd_corner_reg[15:0]};
    assign by_l = {rd_corner_reg[31], rd_corner_reg[31:16]};
    assign bx_r = bx_l + $signed({2'b00, rd_size_reg[14:0]});
    assign by_r = by_l + $signed({2'b00, rd_size_reg[29:15]});

    assign iw_s = {xr_min_reg[16], xr_min_reg} - {xl_max_reg[16], xl_max_reg};
    assign ih_s = {yr_min_reg[16], yr_min_reg} - {yl_max_reg[16], yl_max_reg};

    assign area_a_next = box_reg.box_width * box_reg.box_height;
    assign inter_next  = ov_reg ? (iw_reg * ih_reg) : 30'd0;
    assign uni_next    = {1'b0, area_a_reg} + {1'b0, area_b4_reg} - {1'b0, inter4_reg};
    assign rhs_next    = thr_reg * uni_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THR_RESET;
            kept_count_reg  <= '0;
            scan_idx_reg    <= '0;
            box_counter_reg <= '0;
            suppress_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            v_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
            v_reg <= {v_reg[5:1], cmd.issue};
            if (cmd.capture)
            begin
                scan_idx_reg <= '0;
                suppress_reg <= 1'b0;
            end
            else if (cmd.issue)
            begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (v_reg[6] && ({2'b00, lhs_reg} > rhs_reg))
            begin
                suppress_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                if (box_reg.last_box)
                begin
                    kept_count_reg  <= '0;
                    box_counter_reg <= '0;
                end
                else
                begin
                    if (store_wr)
                    begin
                        kept_count_reg <= kept_count_reg + CW'(1);
                    end
                    if (box_counter_reg != BW'(MAX_BOXES - 1))
                    begin
                        box_counter_reg <= box_counter_reg + BW'(1);
                    end
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            corner_mem[kept_count_reg[AW-1:0]] <= {box_reg.box_y, box_reg.box_x};
            size_mem[kept_count_reg[AW-1:0]]   <= {box_reg.box_height, box_reg.box_width};
            area_mem[kept_count_reg[AW-1:0]]   <= area_a_reg;
        end
        rd_corner_reg <= corner_mem[scan_idx_reg[AW-1:0]];
        rd_size_reg   <= size_mem[scan_idx_reg[AW-1:0]];
        rd_area_reg   <= area_mem[scan_idx_reg[AW-1:0]];
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            box_reg <= in_data;
        end
        if (cmd.area)
        begin
            area_a_reg <= area_a_next;
        end
        // overlap edges
        xr_min_reg  <= (ax_r < bx_r) ? ax_r : bx_r;
        xl_max_reg  <= (ax_l > bx_l) ? ax_l : bx_l;
        yr_min_reg  <= (ay_r < by_r) ? ay_r : by_r;
        yl_max_reg  <= (ay_l > by_l) ? ay_l : by_l;
        area_b2_reg <= rd_area_reg;
        // overlap extent; positive extent never exceeds 15 bits
        ov_reg      <= !iw_s[17] && (iw_s != '0) && !ih_s[17] && (ih_s != '0);
        iw_reg      <= iw_s[14:0];
        ih_reg      <= ih_s[14:0];
        area_b3_reg <= area_b2_reg;
        inter4_reg  <= inter_next;
        area_b4_reg <= area_b3_reg;
        uni_reg     <= uni_next;
        inter5_reg  <= inter4_reg;
        lhs_reg     <= {inter5_reg, 8'd0};
        rhs_reg     <= rhs_next;
        if (out_load)
        begin
            out_reg.box_index  <= idx_sat;
            out_reg.kept       <= keep && room;
            out_reg.store_full <= keep && !room;
            out_reg.end_of_set <= box_reg.last_box;
        end
    end

endmodule

>>> src/gbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks on the greedy box suppression block.
// ----------------------------------------------------------------------------
module gbs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input gbs_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_ready,
    input gbs_pkg::out_t out_data
);
    import gbs_pkg::*;

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("verdict dropped or changed while stalled");

    // a stalled box holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> $stable(in_data))
        else $error("input box changed while stalled");

    // a box is either kept or flagged full, never both
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.kept && out_data.store_full))
        else $error("box both kept and flagged full");

    // after a transfer in, the block stays busy before it takes a next box
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("next box taken before the current one was scanned");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
